// ----- rtl/vmrim_pkg.sv -----
// ---------------------------------------------------------------------------
// vmrim_pkg
// Shared types and constants for the variable-length message ring index
// manager: command and error codes, controller states, default sizes.
// ---------------------------------------------------------------------------
package vmrim_pkg;

  localparam int DEF_MAX_FRAMES   = 128;
  localparam int DEF_FRAME_BYTES  = 64;
  localparam int DEF_HEADER_BYTES = 8;

  localparam logic [7:0] FRAMES_IN_USE_RESET = 8'd100;
  localparam logic [7:0] LEN_SAT             = 8'd255;

  // widths fixed by the port fields
  localparam int POS_W   = 8;
  localparam int BYTES_W = 16;
  localparam int COUNT_W = 17;

  typedef enum logic [1:0] {
    OP_PUSH_START = 2'd0,
    OP_PUSH_END   = 2'd1,
    OP_POP_START  = 2'd2,
    OP_POP_END    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_EMPTY    = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LEN,
    S_RD,
    S_RD0
  } state_t;

endpackage

// ----- rtl/vmrim_frame_count.sv -----
// ---------------------------------------------------------------------------
// vmrim_frame_count
// Frames needed for a message: ceil((data_bytes + HEADER_BYTES) / FRAME_BYTES)
// by a registered multiply with a reciprocal of the frame size.
// ---------------------------------------------------------------------------
module vmrim_frame_count #(
  parameter int FRAME_BYTES  = vmrim_pkg::DEF_FRAME_BYTES,
  parameter int HEADER_BYTES = vmrim_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vmrim_pkg::BYTES_W-1:0] data_bytes,
  output logic [vmrim_pkg::COUNT_W-1:0] count
);
  import vmrim_pkg::*;

  // dividend below 2^T_W for all field values if header+frame bytes <= 65537
  localparam int T_W      = 17;
  localparam int LOG_FB   = $clog2(FRAME_BYTES);
  localparam int SHIFT    = T_W + LOG_FB;
  localparam int RECIP_W  = T_W + 1;
  localparam int PROD_W   = T_W + RECIP_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  logic [T_W-1:0]    dividend;
  logic [PROD_W-1:0] product;

  assign dividend = T_W'(data_bytes) + T_W'(HEADER_BYTES) + T_W'(FRAME_BYTES - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      product <= PROD_W'(dividend) * PROD_W'(RECIP);
    end
  end

  // exact floor for any dividend below 2^T_W
  assign count = COUNT_W'(product >> SHIFT);

endmodule

// ----- rtl/variable_message_ring_index_manager.sv -----
// ---------------------------------------------------------------------------
// variable_message_ring_index_manager
// Keeps write and read frame positions of a ring of fixed-size frames and a
// length store with one entry per frame; handles push and pop commands.
// ---------------------------------------------------------------------------
// sequence: push start, push end on a full ring and pops on an empty ring
//   answer from EXEC; other push ends answer from LEN after the registered
//   frame-count multiply; pops read the length store and answer from RD, pop
//   start from RD0 on a wrap mark. A new command is taken only back in idle,
//   after the result is loaded; out_stall holds the controller meanwhile
// reset: positions go to 0, frames_in_use to 100; the length store is not
//   cleared, no clearing pass runs, commands are taken the cycle after reset
module variable_message_ring_index_manager #(
  parameter int MAX_FRAMES   = vmrim_pkg::DEF_MAX_FRAMES,
  parameter int FRAME_BYTES  = vmrim_pkg::DEF_FRAME_BYTES,
  parameter int HEADER_BYTES = vmrim_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [vmrim_pkg::BYTES_W-1:0] data_bytes,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          granted,
  output logic [6:0]                    frame_index,
  output logic [7:0]                    message_frames,
  output logic [1:0]                    error_code,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    frames_in_use
);
  import vmrim_pkg::*;

  localparam int ADDR_W = $clog2(MAX_FRAMES);

  function automatic logic [31:0] slot(input logic [POS_W-1:0] p);
    logic [31:0] x;
    x = 32'(p);
    return (x < 32'(MAX_FRAMES)) ? x : 32'd0;
  endfunction

  state_t state, state_next;
  op_t    op_q;

  logic [7:0]       ring_cfg;
  logic [POS_W-1:0] wr_pos, wr_pos_next;
  logic [POS_W-1:0] rd_pos, rd_pos_next;
  logic [POS_W-1:0] n_frames;

  // length store
  logic [7:0]        len_mem [MAX_FRAMES];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  logic               fc_en;
  logic [COUNT_W-1:0] fc_count;
  logic [BYTES_W-1:0] data_bytes_q;

  logic       out_free, out_load;
  logic       res_granted;
  logic [6:0] res_index;
  logic [7:0] res_frames;
  err_t       res_err;

  // push start terms
  logic             ps_refuse_end, ps_wrap, ps_refuse_full;
  logic [POS_W-1:0] ps_w0, ps_w1;
  logic [31:0]      ps_slot_w0, ps_slot_w1;
  // push end terms
  logic             pe_full, pe_overflow;
  logic [7:0]       pe_len;
  logic [COUNT_W:0] pe_next;
  logic [31:0]      slot_rd_w;
  // pop terms
  logic             pop_empty, pop_live;
  logic [POS_W-1:0] rd_eff, rd_adv;
  logic [POS_W:0]   rd_sum;
  logic [31:0]      slot_rd_eff, slot_rd;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign n_frames = (32'(ring_cfg) < 32'(MAX_FRAMES)) ? ring_cfg : POS_W'(MAX_FRAMES);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_cfg <= FRAMES_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ring_cfg <= frames_in_use;
    end
  end

  vmrim_frame_count #(
    .FRAME_BYTES (FRAME_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_frame_count (
    .clk       (clk),
    .en        (fc_en),
    .data_bytes(data_bytes_q),
    .count     (fc_count)
  );

  // push start
  assign ps_refuse_end  = (wr_pos >= n_frames) && (rd_pos == '0);
  assign ps_w0          = (wr_pos >= n_frames) ? '0 : wr_pos;
  assign ps_wrap        = (ps_w0 == rd_pos) && (rd_pos > (n_frames >> 1));
  assign ps_w1          = ps_wrap ? '0 : ps_w0;
  assign ps_refuse_full = (rd_pos != '0) && (ps_w1 == rd_pos - POS_W'(1));
  assign ps_slot_w0     = slot(ps_w0);
  assign ps_slot_w1     = slot(ps_w1);

  // push end
  assign pe_full     = (wr_pos >= n_frames) ||
                       ((rd_pos != '0) && (wr_pos == rd_pos - POS_W'(1)));
  assign pe_len      = (fc_count > COUNT_W'(LEN_SAT)) ? LEN_SAT : fc_count[7:0];
  assign pe_next     = (COUNT_W+1)'(wr_pos) + (COUNT_W+1)'(fc_count);
  assign pe_overflow = (pe_next > (COUNT_W+1)'(n_frames)) ||
                       ((wr_pos < rd_pos) && (pe_next >= (COUNT_W+1)'(rd_pos)));

  // pop: a read position past the ring end wraps unless it meets write
  assign pop_empty   = (rd_pos == wr_pos) || ((rd_pos >= n_frames) && (wr_pos == '0));
  assign rd_eff      = ((rd_pos != wr_pos) && (rd_pos >= n_frames)) ? '0 : rd_pos;
  assign slot_rd_eff = slot(rd_eff);
  assign slot_rd     = slot(rd_pos);
  assign pop_live    = (rd_pos < wr_pos) || (mem_rdata != 8'd0);
  assign rd_sum      = (POS_W+1)'(rd_pos) + (POS_W+1)'(mem_rdata);
  assign rd_adv      = (rd_sum > (POS_W+1)'(n_frames)) ? n_frames : rd_sum[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wr_pos <= '0;
      rd_pos <= '0;
    end else begin
      state  <= state_next;
      wr_pos <= wr_pos_next;
      rd_pos <= rd_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q         <= op_t'(op);
      data_bytes_q <= data_bytes;
    end
  end

  always_comb begin
    state_next  = state;
    wr_pos_next = wr_pos;
    rd_pos_next = rd_pos;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = 8'd0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    fc_en       = 1'b0;
    out_load    = 1'b0;
    res_granted = 1'b0;
    res_index   = 7'd0;
    res_frames  = 8'd0;
    res_err     = ERR_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_PUSH_START: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = S_IDLE;
              if (!ps_refuse_end) begin
                wr_pos_next = ps_w1;
                mem_we      = ps_wrap;
                mem_waddr   = ps_slot_w0[ADDR_W-1:0];
                res_granted = !ps_refuse_full;
                res_index   = ps_refuse_full ? 7'd0 : ps_slot_w1[6:0];
              end
            end
          end
          OP_PUSH_END: begin
            if (pe_full) begin
              if (out_free) begin
                out_load   = 1'b1;
                res_err    = ERR_FULL;
                state_next = S_IDLE;
              end
            end else begin
              fc_en      = 1'b1;
              state_next = S_LEN;
            end
          end
          default: begin
            if (pop_empty) begin
              if (out_free) begin
                rd_pos_next = rd_eff;
                out_load    = 1'b1;
                res_err     = (op_q == OP_POP_END) ? ERR_EMPTY : ERR_NONE;
                state_next  = S_IDLE;
              end
            end else begin
              rd_pos_next = rd_eff;
              mem_re      = 1'b1;
              mem_raddr   = slot_rd_eff[ADDR_W-1:0];
              state_next  = S_RD;
            end
          end
        endcase
      end
      S_LEN: begin
        if (out_free) begin
          mem_we      = 1'b1;
          mem_waddr   = slot_rd_w[ADDR_W-1:0];
          mem_wdata   = pe_len;
          out_load    = 1'b1;
          state_next  = S_IDLE;
          if (pe_overflow) begin
            res_err = ERR_OVERFLOW;
          end else begin
            wr_pos_next = pe_next[POS_W-1:0];
            res_granted = 1'b1;
          end
        end
      end
      S_RD: begin
        if (op_q == OP_POP_START) begin
          if (pop_live) begin
            if (out_free) begin
              out_load    = 1'b1;
              res_granted = 1'b1;
              res_index   = slot_rd[6:0];
              res_frames  = mem_rdata;
              state_next  = S_IDLE;
            end
          end else begin
            // wrap mark at the head: the message starts at frame 0
            rd_pos_next = '0;
            mem_re      = 1'b1;
            mem_raddr   = '0;
            state_next  = S_RD0;
          end
        end else if (out_free) begin
          rd_pos_next = pop_live ? rd_adv : '0;
          out_load    = 1'b1;
          res_granted = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_RD0: begin
        if (out_free) begin
          out_load    = 1'b1;
          res_granted = 1'b1;
          res_frames  = mem_rdata;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign slot_rd_w = slot(wr_pos);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      len_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= len_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      granted        <= res_granted;
      frame_index    <= res_index;
      message_frames <= res_frames;
      error_code     <= res_err;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted command did not start execution");

  a_refused_is_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (frame_index == 7'd0 && message_frames == 8'd0))
    else $error("refused result carries a frame index or length");

  a_error_not_granted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> !granted)
    else $error("error reported on a granted result");

  a_store_write_on_push: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_EXEC && op_q == OP_PUSH_START) || state == S_LEN))
    else $error("length store written outside a push");

  a_read_pos_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (rd_pos == $past(rd_pos) && wr_pos == $past(wr_pos)))
    else $error("ring position moved while idle");

endmodule
